// ===== rtl/core/fcfb_pkg.sv =====
// Shared types and constants for the fragment combine / fog / blend pipeline.
// No dependencies; every other file in rtl/core but fcfb_checker refers to it by scoped names.
`default_nettype none

package fcfb_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE_FLAGS     = 3'd0;
    localparam logic [2:0] CFG_COLOR_OP       = 3'd1;
    localparam logic [2:0] CFG_TEXTURE_FACTOR = 3'd2;
    localparam logic [2:0] CFG_FOG_COLOR      = 3'd3;
    localparam logic [2:0] CFG_FOG_FAR        = 3'd4;
    localparam logic [2:0] CFG_FOG_INV_RANGE  = 3'd5;

    // Bit positions in mode_flags
    localparam int FLAG_TEXTURED  = 0;
    localparam int FLAG_DIFF_ARG2 = 1;
    localparam int FLAG_FOG       = 2;
    localparam int FLAG_INV_BLEND = 3;
    localparam int FLAG_ZTEST     = 4;
    localparam int FLAG_ZMASK     = 5;
    localparam int FLAG_LEQUAL    = 6;

    localparam logic [7:0]  ALPHA_THRESHOLD   = 8'd4;
    localparam logic [31:0] FOG_INV_RANGE_RST = 32'h0001_0000;
    localparam logic [24:0] FOG_ONE           = 25'h100_0000;

    typedef enum logic [1:0] {
        OP_MODULATE = 2'd0,
        OP_ADD      = 2'd1,
        OP_REPLACE  = 2'd2,
        OP_WHITE    = 2'd3
    } t_color_op;

    typedef struct packed {
        logic [6:0]         mode_flags;
        t_color_op          color_op;
        logic [31:0]        texture_factor;
        logic [31:0]        fog_color;
        logic signed [23:0] fog_far;
        logic [31:0]        fog_inv_range;
    } t_cfg;

    // One fragment as it moves down the pipe
    typedef struct packed {
        logic [31:0]        color;
        logic [31:0]        dest;
        logic [23:0]        depth;
        logic signed [24:0] fog_dist;
        logic               pass;
        logic               fog_en;
        logic               inv_blend;
        logic               depth_wr_en;
    } t_frag;

endpackage

`default_nettype wire

// ===== rtl/core/fragment_combine_fog_blend_top.sv =====
// Top level of the fragment combine / fog / blend pipeline: configuration registers
// and the chain fcfb_combine -> fcfb_fog -> fcfb_blend. Depends on fcfb_pkg.
`default_nettype none

// One covered fragment enters per clock unless stalled, and one pixel decision leaves
// per fragment after a combine stage (depth test and the 8x8 channel products), three
// fog stages (the 25x32 distance times reciprocal-range product, the clamp to an 8-bit
// lerp weight, the per-channel lerp) and a blend stage that holds the output register.
// Each stage carries its own valid bit; a stall at the output holds only the stages
// that are full, so bubbles close up and the input keeps taking fragments while any
// stage has room. Fragments rejected by the depth or alpha test still produce a result
// carrying the unchanged framebuffer color with both write enables low. Configuration
// is taken on any cycle with the write enable high and must only change while no
// fragment is in flight; indexes beyond the last register are dropped.
module fragment_combine_fog_blend_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [31:0]        i_texel_color,
    input  wire logic [31:0]        i_diffuse_color,
    input  wire logic signed [23:0] i_fog_depth,
    input  wire logic [23:0]        i_frag_depth,
    input  wire logic [23:0]        i_stored_depth,
    input  wire logic [31:0]        i_dest_color,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [31:0]             o_pixel_out,
    output logic                    o_color_write,
    output logic                    o_depth_write,
    output logic [23:0]             o_depth_out
);

    fcfb_pkg::t_cfg r_cfg;

    // Configuration registers; writes to unused indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode_flags     <= '0;
            r_cfg.color_op       <= fcfb_pkg::OP_MODULATE;
            r_cfg.texture_factor <= '0;
            r_cfg.fog_color      <= '0;
            r_cfg.fog_far        <= '0;
            r_cfg.fog_inv_range  <= fcfb_pkg::FOG_INV_RANGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fcfb_pkg::CFG_MODE_FLAGS:     r_cfg.mode_flags     <= i_cfg_data[6:0];
                fcfb_pkg::CFG_COLOR_OP:
                    r_cfg.color_op <= fcfb_pkg::t_color_op'(i_cfg_data[1:0]);
                fcfb_pkg::CFG_TEXTURE_FACTOR: r_cfg.texture_factor <= i_cfg_data;
                fcfb_pkg::CFG_FOG_COLOR:      r_cfg.fog_color      <= i_cfg_data;
                fcfb_pkg::CFG_FOG_FAR:        r_cfg.fog_far        <= $signed(i_cfg_data[23:0]);
                fcfb_pkg::CFG_FOG_INV_RANGE:  r_cfg.fog_inv_range  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage-to-stage transfer signals
    logic            comb_valid, comb_stall;
    fcfb_pkg::t_frag comb_frag;
    logic            fog_valid, fog_stall;
    fcfb_pkg::t_frag fog_frag;

    fcfb_combine u_combine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_texel_color   (i_texel_color),
        .i_diffuse_color (i_diffuse_color),
        .i_fog_depth     (i_fog_depth),
        .i_frag_depth    (i_frag_depth),
        .i_stored_depth  (i_stored_depth),
        .i_dest_color    (i_dest_color),
        .o_valid         (comb_valid),
        .i_stall         (comb_stall),
        .o_frag          (comb_frag)
    );

    fcfb_fog u_fog (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (comb_valid),
        .o_stall (comb_stall),
        .i_frag  (comb_frag),
        .o_valid (fog_valid),
        .i_stall (fog_stall),
        .o_frag  (fog_frag)
    );

    fcfb_blend u_blend (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (fog_valid),
        .o_stall       (fog_stall),
        .i_frag        (fog_frag),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_out   (o_pixel_out),
        .o_color_write (o_color_write),
        .o_depth_write (o_depth_write),
        .o_depth_out   (o_depth_out)
    );

endmodule

`default_nettype wire

// ===== rtl/core/fcfb_combine.sv =====
// First pipeline stage: depth test, argument select, color combine and fog distance.
// Depends on fcfb_pkg.
`default_nettype none

module fcfb_combine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fcfb_pkg::t_cfg      i_cfg,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [31:0]         i_texel_color,
    input  wire logic [31:0]         i_diffuse_color,
    input  wire logic signed [23:0]  i_fog_depth,
    input  wire logic [23:0]         i_frag_depth,
    input  wire logic [23:0]         i_stored_depth,
    input  wire logic [31:0]         i_dest_color,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output fcfb_pkg::t_frag          o_frag
);

    logic            r_valid;
    fcfb_pkg::t_frag r_frag;
    fcfb_pkg::t_frag n_frag;

    logic [31:0] arg1;
    logic [31:0] arg2;
    logic [31:0] modulated;
    logic [15:0] prod [4];
    logic        ztest;

    always_comb begin
        arg1 = i_cfg.mode_flags[fcfb_pkg::FLAG_TEXTURED] ? i_texel_color : i_diffuse_color;
        arg2 = i_cfg.mode_flags[fcfb_pkg::FLAG_DIFF_ARG2] ? i_diffuse_color
                                                          : i_cfg.texture_factor;
        for (int i = 0; i < 4; i++) begin
            prod[i] = {8'h00, arg1[8*i +: 8]} * {8'h00, arg2[8*i +: 8]};
            modulated[8*i +: 8] = prod[i][15:8];
        end
    end

    always_comb begin
        ztest = i_cfg.mode_flags[fcfb_pkg::FLAG_ZTEST];
        n_frag.pass = !(ztest && i_cfg.mode_flags[fcfb_pkg::FLAG_LEQUAL]
                        && (i_frag_depth > i_stored_depth));
        case (i_cfg.color_op)
            fcfb_pkg::OP_MODULATE: n_frag.color = modulated;
            fcfb_pkg::OP_ADD: begin
                // alpha still modulates; color channels wrap
                n_frag.color = {modulated[31:24],
                                arg1[23:16] + arg2[23:16],
                                arg1[15:8] + arg2[15:8],
                                arg1[7:0] + arg2[7:0]};
            end
            fcfb_pkg::OP_REPLACE: n_frag.color = arg1;
            default:              n_frag.color = 32'hFFFF_FFFF;
        endcase
        n_frag.dest        = i_dest_color;
        n_frag.depth       = i_frag_depth;
        n_frag.fog_dist    = $signed({i_cfg.fog_far[23], i_cfg.fog_far})
                           - $signed({i_fog_depth[23], i_fog_depth});
        n_frag.fog_en      = i_cfg.mode_flags[fcfb_pkg::FLAG_FOG];
        n_frag.inv_blend   = i_cfg.mode_flags[fcfb_pkg::FLAG_INV_BLEND];
        n_frag.depth_wr_en = ztest && i_cfg.mode_flags[fcfb_pkg::FLAG_ZMASK];
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_frag <= n_frag;
        end
    end

    assign o_valid = r_valid;
    assign o_frag  = r_frag;

endmodule

`default_nettype wire

// ===== rtl/core/fcfb_fog.sv =====
// Fog stages: distance times reciprocal range, clamp to lerp weight, per-channel lerp.
// Three register stages; depends on fcfb_pkg.
`default_nettype none

module fcfb_fog (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire fcfb_pkg::t_cfg  i_cfg,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire fcfb_pkg::t_frag i_frag,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output fcfb_pkg::t_frag      o_frag
);

    logic                r_v2, r_v3, r_v4;
    fcfb_pkg::t_frag     r_f2, r_f3, r_f4;
    logic signed [57:0]  r_prod;
    logic [7:0]          r_t;

    logic signed [57:0]  n_prod;
    logic [24:0]         coef;
    logic [32:0]         scaled;
    logic [7:0]          n_t;
    fcfb_pkg::t_frag     n_f4;
    logic [16:0]         mix [3];

    logic stall2, stall3, stall4;

    assign stall4  = r_v4 && i_stall;
    assign stall3  = r_v3 && stall4;
    assign stall2  = r_v2 && stall3;
    assign o_stall = stall2;

    assign n_prod = $signed(i_frag.fog_dist) * $signed({1'b0, i_cfg.fog_inv_range});

    always_comb begin
        if (r_prod[57]) begin
            coef = '0;
        end else if ((r_prod[56:25] != '0) || (r_prod[24] && (r_prod[23:0] != '0))) begin
            coef = fcfb_pkg::FOG_ONE;
        end else begin
            coef = r_prod[24:0];
        end
        scaled = {coef, 8'h00} - {8'h00, coef};
        n_t    = 8'hFF - scaled[31:24];
    end

    always_comb begin
        n_f4 = r_f3;
        for (int i = 0; i < 3; i++) begin
            mix[i] = {9'h000, r_f3.color[8*i +: 8]} * {9'h000, ~r_t}
                   + {9'h000, i_cfg.fog_color[8*i +: 8]} * {9'h000, r_t};
        end
        if (r_f3.fog_en) begin
            n_f4.color = {r_f3.color[31:24], mix[2][15:8], mix[1][15:8], mix[0][15:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (!stall2) r_v2 <= i_valid;
            if (!stall3) r_v3 <= r_v2;
            if (!stall4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall2 && i_valid) begin
            r_f2   <= i_frag;
            r_prod <= n_prod;
        end
        if (!stall3 && r_v2) begin
            r_f3 <= r_f2;
            r_t  <= n_t;
        end
        if (!stall4 && r_v3) begin
            r_f4 <= n_f4;
        end
    end

    assign o_valid = r_v4;
    assign o_frag  = r_f4;

endmodule

`default_nettype wire

// ===== rtl/core/fcfb_blend.sv =====
// Last stage: alpha test, blend with the framebuffer pixel, write enables, output register.
// Depends on fcfb_pkg.
`default_nettype none

module fcfb_blend (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire fcfb_pkg::t_frag i_frag,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [31:0]          o_pixel_out,
    output logic                 o_color_write,
    output logic                 o_depth_write,
    output logic [23:0]          o_depth_out
);

    logic        r_valid;
    logic [31:0] r_pixel;
    logic        r_cw;
    logic        r_dw;
    logic [23:0] r_depth;

    logic [7:0]  sa;
    logic [7:0]  da;
    logic [16:0] acc [3];
    logic [7:0]  chan_out [3];
    logic        cw;
    logic        dw;

    always_comb begin
        sa = i_frag.color[31:24];
        da = i_frag.inv_blend ? (8'hFF - sa) : 8'hFF;
        for (int i = 0; i < 3; i++) begin
            acc[i] = {9'h000, i_frag.color[8*i +: 8]} * {9'h000, sa}
                   + {9'h000, i_frag.dest[8*i +: 8]} * {9'h000, da}
                   + 17'd128;
            chan_out[i] = acc[i][16] ? 8'hFF : acc[i][15:8];
        end
        cw = i_frag.pass && (sa >= fcfb_pkg::ALPHA_THRESHOLD);
        dw = cw && i_frag.depth_wr_en;
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_pixel <= cw ? {sa, chan_out[2], chan_out[1], chan_out[0]} : i_frag.dest;
            r_cw    <= cw;
            r_dw    <= dw;
            r_depth <= dw ? i_frag.depth : 24'h000000;
        end
    end

    assign o_valid       = r_valid;
    assign o_pixel_out   = r_pixel;
    assign o_color_write = r_cw;
    assign o_depth_write = r_dw;
    assign o_depth_out   = r_depth;

endmodule

`default_nettype wire

// ===== rtl/core/fcfb_checker.sv =====
// Port-level checks for fragment_combine_fog_blend_top and the bind that attaches them.
// Depends only on the top level's ports.
`default_nettype none

module fcfb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_pixel_out,
    input wire logic        o_color_write,
    input wire logic        o_depth_write,
    input wire logic [23:0] o_depth_out
);

    // Depth is written only for fragments whose color is written
    a_dw_implies_cw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_depth_write |-> o_color_write)
        else $error("depth write without color write");

    // Depth output stays zero when no depth write
    a_depth_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_depth_write |-> o_depth_out == 24'h000000)
        else $error("depth output nonzero without depth write");

    // A written pixel has passed the alpha test
    a_alpha_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_color_write |-> o_pixel_out[31:24] >= 8'd4)
        else $error("color write with alpha below threshold");

    // Pipe is empty the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_out) && $stable(o_color_write))
        else $error("stalled result changed");

endmodule

bind fragment_combine_fog_blend_top fcfb_checker u_fcfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_pixel_out   (o_pixel_out),
    .o_color_write (o_color_write),
    .o_depth_write (o_depth_write),
    .o_depth_out   (o_depth_out)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for fragment_combine_fog_blend_top: drives fragments and register writes,
// predicts each pixel decision in-bench and checks the results in order.
// Depends on fcfb_pkg and the RTL under rtl/core.
module tb;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_FRAGS = 1150;
    // Pipeline is five deep; clocks to wait before touching registers or ending
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;

    // Register indexes past the last register; writes there must be dropped
    localparam logic [2:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [2:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [31:0]        texel;
        logic [31:0]        diffuse;
        logic signed [23:0] fog_z;
        logic [23:0]        frag_z;
        logic [23:0]        stored_z;
        logic [31:0]        dest;
    } t_frag_in;

    typedef struct packed {
        logic [31:0] pixel;
        logic        color_wr;
        logic        depth_wr;
        logic [23:0] depth;
    } t_decision;

    typedef enum int {
        PACE_FULL,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } t_pace;

    // Holds predicted pixel decisions in transfer order and checks each result
    // against the oldest one.
    class pixel_scoreboard;
        t_decision pending[$];
        int        mismatches;

        function void note_frag(t_decision want);
            pending = {pending, want};
        endfunction

        function void check_decision(t_decision got);
            t_decision want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: pixel %h cw %b dw %b depth %h",
                             got.pixel, got.color_wr, got.depth_wr, got.depth);
                return;
            end
            want = pending.pop_front();
            if (got.pixel !== want.pixel || got.color_wr !== want.color_wr ||
                got.depth_wr !== want.depth_wr || got.depth !== want.depth) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"mismatch: expected pixel %h cw %b dw %b depth %h, ",
                              "got pixel %h cw %b dw %b depth %h"},
                             want.pixel, want.color_wr, want.depth_wr, want.depth,
                             got.pixel, got.color_wr, got.depth_wr, got.depth);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [31:0]        i_texel_color;
    logic [31:0]        i_diffuse_color;
    logic signed [23:0] i_fog_depth;
    logic [23:0]        i_frag_depth;
    logic [23:0]        i_stored_depth;
    logic [31:0]        i_dest_color;
    logic               o_valid;
    logic               i_stall;
    logic [31:0]        o_pixel_out;
    logic               o_color_write;
    logic               o_depth_write;
    logic [23:0]        o_depth_out;

    pixel_scoreboard board;
    fcfb_pkg::t_cfg  shadow;          // register contents as the block should hold them
    int              send_gap_pct;
    int              recv_stall_pct;
    int              cycle_count;

    fragment_combine_fog_blend_top DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output side: check every result transfer, then pick the next stall value.
    // Values read here are the ones present before this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_decision('{o_pixel_out, o_color_write, o_depth_write, o_depth_out});
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Predict one pixel decision: depth test, combine, fog, alpha test, blend.
    function automatic t_decision predict_pixel(fcfb_pkg::t_cfg c, t_frag_in f);
        t_decision          r;
        logic [31:0]        arg_a;
        logic [31:0]        arg_b;
        logic [31:0]        mixed;
        logic signed [63:0] dz;
        logic signed [63:0] coef;
        logic signed [63:0] scaled;
        int unsigned        sa;
        int unsigned        da;
        int unsigned        wt;
        int unsigned        acc;
        logic               ztest;
        int                 k;
        r.pixel    = f.dest;
        r.color_wr = 1'b0;
        r.depth_wr = 1'b0;
        r.depth    = '0;
        ztest = c.mode_flags[fcfb_pkg::FLAG_ZTEST];
        // Compare only counts when both the test and the lequal flag are on
        if (ztest && c.mode_flags[fcfb_pkg::FLAG_LEQUAL] && f.frag_z > f.stored_z)
            return r;

        arg_a = c.mode_flags[fcfb_pkg::FLAG_TEXTURED]  ? f.texel   : f.diffuse;
        arg_b = c.mode_flags[fcfb_pkg::FLAG_DIFF_ARG2] ? f.diffuse : c.texture_factor;
        case (c.color_op)
            fcfb_pkg::OP_MODULATE: begin
                for (k = 0; k < 4; k++) begin
                    acc = arg_a[8*k +: 8] * arg_b[8*k +: 8];
                    mixed[8*k +: 8] = 8'(acc >> 8);
                end
            end
            fcfb_pkg::OP_ADD: begin
                // Color channels wrap, alpha still modulates
                for (k = 0; k < 3; k++)
                    mixed[8*k +: 8] = arg_a[8*k +: 8] + arg_b[8*k +: 8];
                acc = arg_a[31:24] * arg_b[31:24];
                mixed[31:24] = 8'(acc >> 8);
            end
            fcfb_pkg::OP_REPLACE: mixed = arg_a;
            default:              mixed = '1;
        endcase

        if (c.mode_flags[fcfb_pkg::FLAG_FOG]) begin
            dz = {{40{c.fog_far[23]}}, c.fog_far} - {{40{f.fog_z[23]}}, f.fog_z};
            coef = dz * $signed({32'd0, c.fog_inv_range});
            if (coef < 0)
                coef = 0;
            if (coef > 64'sd16777216)
                coef = 64'sd16777216;
            scaled = (coef * 255) >>> 24;
            wt = 255 - 32'(scaled);
            // Lerp toward the fog color by wt; alpha passes through
            for (k = 0; k < 3; k++) begin
                acc = mixed[8*k +: 8] * (255 - wt) + c.fog_color[8*k +: 8] * wt;
                mixed[8*k +: 8] = 8'(acc >> 8);
            end
        end

        sa = mixed[31:24];
        da = c.mode_flags[fcfb_pkg::FLAG_INV_BLEND] ? 255 - sa : 255;
        if (sa >= fcfb_pkg::ALPHA_THRESHOLD) begin
            r.color_wr = 1'b1;
            r.depth_wr = ztest && c.mode_flags[fcfb_pkg::FLAG_ZMASK];
            r.depth    = r.depth_wr ? f.frag_z : '0;
            r.pixel[31:24] = mixed[31:24];
            for (k = 0; k < 3; k++) begin
                acc = (mixed[8*k +: 8] * sa + f.dest[8*k +: 8] * da + 128) >> 8;
                r.pixel[8*k +: 8] = (acc > 255) ? 8'd255 : 8'(acc);
            end
        end
        return r;
    endfunction

    function automatic t_frag_in make_frag(logic [31:0] texel, logic [31:0] diffuse,
                                           logic [23:0] fog_z, logic [23:0] frag_z,
                                           logic [23:0] stored_z, logic [31:0] dest);
        t_frag_in f;
        f.texel    = texel;
        f.diffuse  = diffuse;
        f.fog_z    = fog_z;
        f.frag_z   = frag_z;
        f.stored_z = stored_z;
        f.dest     = dest;
        return f;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Random register set, with the extremes turning up now and then
    function automatic fcfb_pkg::t_cfg rand_cfg();
        fcfb_pkg::t_cfg c;
        c.mode_flags     = 7'($urandom);
        c.color_op       = fcfb_pkg::t_color_op'($urandom_range(0, 3));
        c.texture_factor = pick_word();
        c.fog_color      = pick_word();
        case ($urandom_range(0, 5))
            0:       c.fog_far = 24'sh800000;
            1:       c.fog_far = 24'sh7FFFFF;
            2:       c.fog_far = '0;
            default: c.fog_far = 24'($urandom);
        endcase
        // Keep the fog coefficient off the clamps most of the time
        case ($urandom_range(0, 7))
            0:       c.fog_inv_range = '0;
            1:       c.fog_inv_range = '1;
            2:       c.fog_inv_range = $urandom;
            default: c.fog_inv_range = $urandom_range(256, 1 << 18);
        endcase
        return c;
    endfunction

    // Random fragment; fog depth lands near fog_far for half of them so the
    // lerp weight takes values between the clamps.
    function automatic t_frag_in rand_frag(fcfb_pkg::t_cfg c);
        t_frag_in    f;
        int unsigned span;
        f.texel   = $urandom;
        f.diffuse = $urandom;
        f.dest    = $urandom;
        if ($urandom_range(0, 7) == 0)
            f.texel[31:24] = 8'($urandom_range(0, 5));
        if ($urandom_range(0, 7) == 0)
            f.diffuse[31:24] = 8'($urandom_range(0, 5));
        span = (c.fog_inv_range == 0) ? 32'hFFFF : (32'h0200_0000 / c.fog_inv_range) + 1;
        if ($urandom_range(0, 1) == 0)
            f.fog_z = 24'($urandom);
        else
            f.fog_z = c.fog_far - 24'($urandom_range(0, span));
        f.stored_z = 24'($urandom);
        case ($urandom_range(0, 2))
            0:       f.frag_z = 24'($urandom);
            1:       f.frag_z = f.stored_z;
            default: f.frag_z = f.stored_z + 24'($urandom_range(0, 2)) - 24'd1;
        endcase
        return f;
    endfunction

    task automatic set_pace(t_pace p);
        case (p)
            PACE_FULL:        begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND_GAPS:   begin send_gap_pct = 68; recv_stall_pct = 0;  end
            PACE_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 68; end
            default:          begin send_gap_pct = 11; recv_stall_pct = 11; end
        endcase
    endtask

    // Write one register and mirror it; leaves the write enable high so that
    // back-to-back writes never drop and raise it in one step.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            fcfb_pkg::CFG_MODE_FLAGS:     shadow.mode_flags     = data[6:0];
            fcfb_pkg::CFG_COLOR_OP:
                shadow.color_op = fcfb_pkg::t_color_op'(data[1:0]);
            fcfb_pkg::CFG_TEXTURE_FACTOR: shadow.texture_factor = data;
            fcfb_pkg::CFG_FOG_COLOR:      shadow.fog_color      = data;
            fcfb_pkg::CFG_FOG_FAR:        shadow.fog_far        = data[23:0];
            fcfb_pkg::CFG_FOG_INV_RANGE:  shadow.fog_inv_range  = data;
            default: ;
        endcase
    endtask

    // Load a full register set, junk in the unused upper bits, plus one write
    // to an index past the end that must be dropped.
    task automatic program_cfg(fcfb_pkg::t_cfg c);
        write_reg(fcfb_pkg::CFG_MODE_FLAGS,     {25'($urandom), c.mode_flags});
        write_reg(fcfb_pkg::CFG_COLOR_OP,       {30'($urandom), c.color_op});
        write_reg(fcfb_pkg::CFG_TEXTURE_FACTOR, c.texture_factor);
        write_reg(fcfb_pkg::CFG_FOG_COLOR,      c.fog_color);
        write_reg(fcfb_pkg::CFG_FOG_FAR,        {8'($urandom), c.fog_far});
        write_reg(fcfb_pkg::CFG_FOG_INV_RANGE,  c.fog_inv_range);
        write_reg($urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one fragment, with random gaps ahead of it; predict it on transfer.
    task automatic drive_frag(t_frag_in f);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_texel_color   <= f.texel;
        i_diffuse_color <= f.diffuse;
        i_fog_depth     <= f.fog_z;
        i_frag_depth    <= f.frag_z;
        i_stored_depth  <= f.stored_z;
        i_dest_color    <= f.dest;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        board.note_frag(predict_pixel(shadow, f));
    endtask

    // Drop valid, wait for every predicted result, then let the pipe empty.
    task automatic finish_phase();
        i_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        fcfb_pkg::t_cfg c;
        logic [31:0]    mode;
        int             random_sent;
        int             phase;
        int             n;
        board = new();
        cycle_count = 0;
        random_sent = 0;
        phase = 0;
        set_pace(PACE_FULL);
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        i_valid         <= 1'b0;
        i_stall         <= 1'b0;
        i_texel_color   <= '0;
        i_diffuse_color <= '0;
        i_fog_depth     <= '0;
        i_frag_depth    <= '0;
        i_stored_depth  <= '0;
        i_dest_color    <= '0;
        shadow.mode_flags     = '0;
        shadow.color_op       = fcfb_pkg::OP_MODULATE;
        shadow.texture_factor = '0;
        shadow.fog_color      = '0;
        shadow.fog_far        = '0;
        shadow.fog_inv_range  = fcfb_pkg::FOG_INV_RANGE_RST;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: zero texture factor, so every fragment fails the alpha test
        drive_frag(make_frag('0, '0, '0, '0, '0, '0));
        drive_frag(make_frag('1, '1, '1, '1, '1, '1));
        finish_phase();

        // Fog on with the reset reciprocal range, replace combine, full depth test
        mode = (1 << fcfb_pkg::FLAG_TEXTURED) | (1 << fcfb_pkg::FLAG_FOG) |
               (1 << fcfb_pkg::FLAG_ZTEST) | (1 << fcfb_pkg::FLAG_ZMASK) |
               (1 << fcfb_pkg::FLAG_LEQUAL);
        write_reg(fcfb_pkg::CFG_MODE_FLAGS, mode);
        write_reg(fcfb_pkg::CFG_COLOR_OP, fcfb_pkg::OP_REPLACE);
        i_cfg_we <= 1'b0;
        drive_frag(make_frag(32'hFF804020, '0, -24'sd128, 24'd100, 24'd200, 32'h11223344));
        drive_frag(make_frag(32'hFF804020, '0, 24'sh800000, 24'h123456, 24'h123456, '1));
        // Depth fails: the framebuffer color comes back untouched
        drive_frag(make_frag(32'h80FFFFFF, '0, 24'sh7FFFFF, 24'hFFFFFF, '0, 32'hA5A5A5A5));
        // Alpha just below and at the threshold
        drive_frag(make_frag(32'h03FFFFFF, '0, -24'sd256, '0, 24'hFFFFFF, 32'h5A5A5A5A));
        drive_frag(make_frag(32'h04FFFFFF, '0, -24'sd256, '0, 24'hFFFFFF, 32'h5A5A5A5A));
        drive_frag(make_frag('1, '0, '0, 24'd10, 24'd11, 32'h80808080));
        finish_phase();

        // Depth test on but lequal off: a farther fragment still passes
        c.mode_flags     = 7'((1 << fcfb_pkg::FLAG_ZTEST) | (1 << fcfb_pkg::FLAG_ZMASK) |
                              (1 << fcfb_pkg::FLAG_DIFF_ARG2) |
                              (1 << fcfb_pkg::FLAG_INV_BLEND));
        c.color_op       = fcfb_pkg::OP_MODULATE;
        c.texture_factor = 32'hC0FFEE80;
        c.fog_color      = 32'h00FF00FF;
        c.fog_far        = '0;
        c.fog_inv_range  = fcfb_pkg::FOG_INV_RANGE_RST;
        program_cfg(c);
        set_pace(PACE_SEND_GAPS);
        drive_frag(make_frag($urandom, 32'hFFFFFFFF, '0, 24'hFFFFFF, '0, $urandom));
        drive_frag(make_frag($urandom, 32'h80808080, '0, '0, '0, $urandom));
        drive_frag(make_frag($urandom, 32'h7F00FF01, '0, 24'd5, 24'd4, $urandom));
        finish_phase();

        // Depth test off: no compare, no depth write; add combine wraps colors
        c.mode_flags     = 7'((1 << fcfb_pkg::FLAG_TEXTURED) | (1 << fcfb_pkg::FLAG_ZMASK));
        c.color_op       = fcfb_pkg::OP_ADD;
        c.texture_factor = '1;
        program_cfg(c);
        set_pace(PACE_RECV_STALLS);
        drive_frag(make_frag(32'hFF010101, '0, '0, 24'hFFFFFF, '0, 32'h00FFFFFF));
        drive_frag(make_frag('0, '1, '0, 24'hFFFFFF, '0, 32'hDEADBEEF));
        drive_frag(make_frag(32'h80FF80FF, '0, '0, '0, '0, 32'h12345678));
        finish_phase();

        // Everything on, constant white, fog coefficient driven into both clamps
        c.mode_flags     = '1;
        c.color_op       = fcfb_pkg::OP_WHITE;
        c.texture_factor = '0;
        c.fog_color      = 32'h00336699;
        c.fog_far        = 24'sh7FFFFF;
        c.fog_inv_range  = '1;
        program_cfg(c);
        set_pace(PACE_BOTH);
        drive_frag(make_frag('0, '0, 24'sh800000, '0, '0, 32'hFFFFFFFF));
        drive_frag(make_frag('0, '0, 24'sh7FFFFF, 24'd7, 24'd7, '0));
        drive_frag(make_frag('0, '0, '0, 24'd1, 24'd0, 32'h0F0F0F0F));
        finish_phase();

        // Fog on with a zero reciprocal range and the most negative far distance
        c.mode_flags     = 7'((1 << fcfb_pkg::FLAG_FOG) | (1 << fcfb_pkg::FLAG_TEXTURED) |
                              (1 << fcfb_pkg::FLAG_INV_BLEND));
        c.color_op       = fcfb_pkg::OP_MODULATE;
        c.texture_factor = '1;
        c.fog_color      = '1;
        c.fog_far        = 24'sh800000;
        c.fog_inv_range  = '0;
        program_cfg(c);
        set_pace(PACE_FULL);
        drive_frag(make_frag('1, '0, '0, '0, '0, '0));
        drive_frag(make_frag(32'h7F7F7F7F, '0, 24'sh7FFFFF, '0, '0, '1));
        finish_phase();

        // Random phases: fresh registers and a new pace each time
        while (random_sent < RANDOM_FRAGS) begin
            program_cfg(rand_cfg());
            set_pace(t_pace'(phase % 4));
            n = $urandom_range(20, 70);
            repeat (n) drive_frag(rand_frag(shadow));
            random_sent += n;
            finish_phase();
            phase++;
        end

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
